>>> src/line_plane_intersection_defines.svh
// ----------------------------------------------------------------------------
// line_plane_intersection_defines
// Assertion macros used by the line/plane intersection back end (lpi_back).
// ----------------------------------------------------------------------------
`ifndef LINE_PLANE_INTERSECTION_DEFINES_SVH
`define LINE_PLANE_INTERSECTION_DEFINES_SVH

// same-cycle implication
`define LPI_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpi check failed");

// next-cycle implication
`define LPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpi check failed");

`endif

>>> src/lpi_pkg.sv
// ----------------------------------------------------------------------------
// lpi_pkg
// Widths, codes and the record that walks through the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none
package lpi_pkg;
   localparam int FRAC_BITS   = 16;
   localparam int COORD_WIDTH = 32;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int UFRAC       = 32;
   // magnitude width of nom and den, also number of quotient bits
   localparam int MAG_WIDTH   = 2 * COORD_WIDTH + 2;
   localparam int SUM_WIDTH   = MAG_WIDTH + 1;
   localparam int DIV_STAGES  = MAG_WIDTH;
   localparam int THR_WIDTH   = 16;
   localparam int UL_WIDTH    = 34;
   localparam int UH_WIDTH    = SUM_WIDTH - UL_WIDTH;

   localparam logic REG_SEGMENT_MODE       = 1'b0;
   localparam logic REG_PARALLEL_THRESHOLD = 1'b1;

   typedef enum logic [1:0] {
      ST_HIT      = 2'd0,
      ST_PARALLEL = 2'd1,
      ST_OUTSIDE  = 2'd2
   } status_type;

   typedef struct packed {
      logic                                  valid;
      logic [MAG_WIDTH-1:0]                  rem;
      logic [MAG_WIDTH-1:0]                  nrest;
      logic [MAG_WIDTH-1:0]                  quo;
      logic [MAG_WIDTH-1:0]                  dmag;
      logic                                  neg;
      logic                                  ovf;
      logic                                  par;
      logic [2:0][COORD_WIDTH-1:0]           p1;
      logic [2:0][DIFF_WIDTH-1:0]            dir;
   } div_type;
endpackage
`default_nettype wire

>>> src/lpi_front.sv
// ----------------------------------------------------------------------------
// lpi_front
// Dot products, nom/den sums, magnitudes and parallel test.
// ----------------------------------------------------------------------------
`default_nettype none
module lpi_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  en,
   input  wire logic                                  in_valid,
   input  wire logic [3:0][lpi_pkg::COORD_WIDTH-1:0]  plane,
   input  wire logic [2:0][lpi_pkg::COORD_WIDTH-1:0]  p1,
   input  wire logic [2:0][lpi_pkg::COORD_WIDTH-1:0]  p2,
   input  wire logic [lpi_pkg::THR_WIDTH-1:0]         thr,
   output lpi_pkg::div_type                           dout
);
   import lpi_pkg::*;

   localparam int PW = 2 * COORD_WIDTH;
   localparam int QW = COORD_WIDTH + DIFF_WIDTH;

   logic                              v1_ff, v2_ff;
   logic signed [PW-1:0]              pn_ff [3];
   logic signed [QW-1:0]              pd_ff [3];
   logic [COORD_WIDTH-1:0]            off_ff;
   logic [2:0][COORD_WIDTH-1:0]       p1_ff, p1b_ff;
   logic [2:0][DIFF_WIDTH-1:0]        dir_ff, dirb_ff, dir_in;
   logic signed [SUM_WIDTH-1:0]       nom_ff, den_ff, nom_in, den_in;
   logic signed [DIFF_WIDTH-1:0]      back [3];
   logic [SUM_WIDTH-1:0]              nabs, dabs;

   // stage 1: point differences and products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         back[k] = $signed({p1[k][COORD_WIDTH-1], p1[k]})
                 - $signed({p2[k][COORD_WIDTH-1], p2[k]});
         dir_in[k] = DIFF_WIDTH'(-back[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            pn_ff[k] <= $signed(plane[k]) * $signed(p1[k]);
            pd_ff[k] <= $signed(plane[k]) * back[k];
         end
         off_ff <= plane[3];
         p1_ff  <= p1;
         dir_ff <= dir_in;
      end
   end

   // stage 2: sums
   always_comb begin
      nom_in = SUM_WIDTH'(pn_ff[0]) + SUM_WIDTH'(pn_ff[1]) + SUM_WIDTH'(pn_ff[2])
             + (SUM_WIDTH'($signed(off_ff)) <<< FRAC_BITS);
      den_in = SUM_WIDTH'(pd_ff[0]) + SUM_WIDTH'(pd_ff[1]) + SUM_WIDTH'(pd_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nom_ff  <= nom_in;
         den_ff  <= den_in;
         p1b_ff  <= p1_ff;
         dirb_ff <= dir_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // magnitudes, parallel test and quotient overflow check
   always_comb begin
      nabs = nom_ff[SUM_WIDTH-1] ? SUM_WIDTH'(-nom_ff) : SUM_WIDTH'(nom_ff);
      dabs = den_ff[SUM_WIDTH-1] ? SUM_WIDTH'(-den_ff) : SUM_WIDTH'(den_ff);
      dout.valid = v2_ff;
      dout.dmag  = dabs[MAG_WIDTH-1:0];
      dout.neg   = nom_ff[SUM_WIDTH-1] ^ den_ff[SUM_WIDTH-1];
      dout.par   = (dabs == '0) ||
                   (dabs < (SUM_WIDTH'(thr) << FRAC_BITS));
      dout.rem   = MAG_WIDTH'(nabs[MAG_WIDTH-1:MAG_WIDTH-UFRAC]);
      dout.ovf   = dout.rem >= dout.dmag;
      dout.nrest = {nabs[MAG_WIDTH-UFRAC-1:0], UFRAC'(0)};
      dout.quo   = '0;
      dout.p1    = p1b_ff;
      dout.dir   = dirb_ff;
   end
endmodule
`default_nettype wire

>>> src/lpi_div_cell.sv
// ----------------------------------------------------------------------------
// lpi_div_cell
// One restoring-division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none
module lpi_div_cell (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  lpi_pkg::div_type din,
   output lpi_pkg::div_type dout
);
   import lpi_pkg::*;

   div_type              data_ff, data_in;
   logic                 valid_ff;
   logic [MAG_WIDTH:0]   trial, diff;
   logic                 take;

   // shift in next numerator bit, try subtracting divisor
   always_comb begin
      trial   = {din.rem, din.nrest[MAG_WIDTH-1]};
      diff    = trial - {1'b0, din.dmag};
      take    = trial >= {1'b0, din.dmag};
      data_in       = din;
      data_in.rem   = take ? diff[MAG_WIDTH-1:0] : trial[MAG_WIDTH-1:0];
      data_in.nrest = din.nrest << 1;
      data_in.quo   = {din.quo[MAG_WIDTH-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= din.valid;
      end
   end

   always_comb begin
      dout       = data_ff;
      dout.valid = valid_ff;
   end
endmodule
`default_nettype wire

>>> src/lpi_back.sv
// ----------------------------------------------------------------------------
// lpi_back
// Parameter clamp, segment test, point interpolation and saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module lpi_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  en,
   input  wire logic                                  segment_mode,
   input  lpi_pkg::div_type                           din,
   output logic                                       out_valid,
   output lpi_pkg::status_type                        out_status,
   output logic [2:0][lpi_pkg::COORD_WIDTH-1:0]       out_hit
);
   import lpi_pkg::*;
   `include "line_plane_intersection_defines.svh"

   localparam int LW   = UL_WIDTH + 1 + DIFF_WIDTH;
   localparam int HW   = UH_WIDTH + DIFF_WIDTH;
   localparam int FW   = HW + UL_WIDTH;
   localparam int SW   = FW - UFRAC;
   localparam int RW   = SW + 1;

   // stage a registers
   logic                           va_ff, vb_ff, vc_ff;
   status_type                     sta_ff, sta_in, stb_ff, stc_ff;
   logic signed [SUM_WIDTH-1:0]    u_ff, u_in;
   logic [2:0][COORD_WIDTH-1:0]    p1a_ff, p1b_ff;
   logic [2:0][DIFF_WIDTH-1:0]     dira_ff;
   logic [MAG_WIDTH-1:0]           umag;
   // stage b registers
   logic signed [LW-1:0]           pl_ff [3];
   logic signed [HW-1:0]           ph_ff [3];
   logic [2:0][COORD_WIDTH-1:0]    hit_ff, hit_in;
   logic signed [FW-1:0]           full [3];
   logic signed [RW-1:0]           sum [3];

   // clamp the quotient, large values saturate the point anyway
   always_comb begin
      umag = (din.ovf || din.quo[MAG_WIDTH-1]) ? {1'b1, (MAG_WIDTH-1)'(0)} : din.quo;
      u_in = din.neg ? -$signed({1'b0, umag}) : $signed({1'b0, umag});
      if (din.par) begin
         sta_in = ST_PARALLEL;
      end else if (segment_mode &&
                   ((din.neg && umag != '0) ||
                    (!din.neg && umag > (MAG_WIDTH'(1) << UFRAC)))) begin
         sta_in = ST_OUTSIDE;
      end else begin
         sta_in = ST_HIT;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff    <= u_in;
         sta_ff  <= sta_in;
         p1a_ff  <= din.p1;
         dira_ff <= din.dir;
      end
   end

   // partial products of u times direction
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            pl_ff[k] <= $signed({1'b0, u_ff[UL_WIDTH-1:0]}) * $signed(dira_ff[k]);
            ph_ff[k] <= $signed(u_ff[SUM_WIDTH-1:UL_WIDTH]) * $signed(dira_ff[k]);
         end
         stb_ff <= sta_ff;
         p1b_ff <= p1a_ff;
      end
   end

   // recombine, floor shift, add start point, saturate
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         full[k] = (FW'(ph_ff[k]) <<< UL_WIDTH) + FW'(pl_ff[k]);
         sum[k]  = RW'($signed(full[k][FW-1:UFRAC])) + RW'($signed(p1b_ff[k]));
         if (stb_ff != ST_HIT) begin
            hit_in[k] = '0;
         end else if (sum[k][RW-1:COORD_WIDTH-1] == '0 ||
                      sum[k][RW-1:COORD_WIDTH-1] == '1) begin
            hit_in[k] = sum[k][COORD_WIDTH-1:0];
         end else if (sum[k][RW-1]) begin
            hit_in[k] = {1'b1, (COORD_WIDTH-1)'(0)};
         end else begin
            hit_in[k] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_in;
         stc_ff <= stb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= din.valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   assign out_valid  = vc_ff;
   assign out_status = stc_ff;
   assign out_hit    = hit_ff;

   `LPI_ASSERT_IMPLY(a_miss_zero, clock, reset, vc_ff && stc_ff != ST_HIT, hit_ff == '0)
   `LPI_ASSERT_IMPLY(a_no_outside, clock, reset, vc_ff && !segment_mode, stc_ff != ST_OUTSIDE)
   `LPI_ASSERT_NEXT(a_par_flows, clock, reset, !reset && en && va_ff && sta_ff == ST_PARALLEL, vb_ff && stb_ff == ST_PARALLEL)
endmodule
`default_nettype wire

>>> src/line_plane_intersection.sv
// ----------------------------------------------------------------------------
// line_plane_intersection
// Streaming line/plane intersection in signed Q16.16.
//
//  channel  dir  contents
//  req_     in   plane A,B,C,D and points P1,P2 (tdata)
//  rsp_     out  status (tuser), hit x,y,z (tdata)
//  csr_     in   segment_mode, parallel_threshold writes
//
// One request per cycle is taken while rsp_ does not stall; the pipeline has two product/sum
// stages, 66 restoring-division cells (one quotient bit each) and three
// interpolation stages. Synchronous active-high reset clears all valid bits
// and the configuration registers. A stall on rsp_ freezes the whole pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module line_plane_intersection (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // normal_a, normal_b, normal_c, plane_offset, start_x, start_y, start_z,
   // end_x, end_y, end_z (32 bits each)
   input  wire logic [10*lpi_pkg::COORD_WIDTH-1:0]   req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // hit_x, hit_y, hit_z (32 bits each)
   output logic [3*lpi_pkg::COORD_WIDTH-1:0]         rsp_tdata,
   // status
   output logic [1:0]                                rsp_tuser,
   input  wire logic                                 csr_wen,
   input  wire logic                                 csr_index,
   input  wire logic [lpi_pkg::THR_WIDTH-1:0]        csr_wdata
);
   import lpi_pkg::*;

   logic                           adv;
   logic                           seg_ff;
   logic [THR_WIDTH-1:0]           thr_ff;
   logic [3:0][COORD_WIDTH-1:0]    plane;
   logic [2:0][COORD_WIDTH-1:0]    p1, p2, hit;
   div_type                        chain [DIV_STAGES+1];
   status_type                     status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= 1'b0;
         thr_ff <= THR_WIDTH'(1);
      end else if (csr_wen) begin
         case (csr_index)
            REG_SEGMENT_MODE:       seg_ff <= csr_wdata[0];
            REG_PARALLEL_THRESHOLD: thr_ff <= csr_wdata[THR_WIDTH-1:0];
            default:                ;
         endcase
      end
   end

   // global advance: output register empty or being taken
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      for (int k = 0; k < 4; k++) plane[k] = req_tdata[k*COORD_WIDTH +: COORD_WIDTH];
      for (int k = 0; k < 3; k++) begin
         p1[k] = req_tdata[(4+k)*COORD_WIDTH +: COORD_WIDTH];
         p2[k] = req_tdata[(7+k)*COORD_WIDTH +: COORD_WIDTH];
      end
   end

   lpi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (req_tvalid),
      .plane    (plane),
      .p1       (p1),
      .p2       (p2),
      .thr      (thr_ff),
      .dout     (chain[0])
   );

   // divider chain
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      lpi_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (adv),
         .din   (chain[i]),
         .dout  (chain[i+1])
      );
   end

   lpi_back u_back (
      .clock        (clock),
      .reset        (reset),
      .en           (adv),
      .segment_mode (seg_ff),
      .din          (chain[DIV_STAGES]),
      .out_valid    (rsp_tvalid),
      .out_status   (status),
      .out_hit      (hit)
   );

   assign rsp_tuser = status;
   assign rsp_tdata = hit;
endmodule
`default_nettype wire
